/* src/sha256_message_padder_assert.svh */
// ----------------------------------------------------------------------------
// SHA-256 message padder assertion macros
// Concurrent assertion shorthands used by the padder datapath.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_PADDER_ASSERT_SVH
`define SHA256_MESSAGE_PADDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHAPAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shapad assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHAPAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shapad assertion failed");

`endif

/* src/shapad_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 padder package
// Operation codes, command and status bundles, and padding constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shapad_pkg;

  // Byte that opens the padding.
  localparam logic [7:0] PAD_BYTE = 8'h80;
  // Word index within the block at which the 64-bit length starts (byte 56).
  localparam logic [3:0] LEN_WORD_IDX = 4'd14;
  // Byte position whose next byte brings the block to 56 bytes.
  localparam logic [5:0] POS_BEFORE_LEN = 6'd55;
  // Bits per message byte, added to the running length.
  localparam logic [63:0] BYTE_BITS = 64'd8;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_PAD_FIRST,
    OP_PAD_ZERO,
    OP_LEN_HI,
    OP_LEN_LO
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic       slot_free;
    logic       at55;
    logic [3:0] word_idx;
  } status_t;

endpackage

/* src/sha256_message_padder.sv */
// Output: a byte that completes a word shows that word in the cycle after its beat.
// Throughput: one message byte per cycle while the output is taken as offered.
// Message end: padding leaves the datapath one word per cycle, 3 to 18 words,
// during which no input beat is taken; the word rate is set by the output register.
// Reset: synchronous, active low; clears position, partial word, length and state.
// ----------------------------------------------------------------------------
// SHA-256 message padder
// Turns a byte stream into padded big-endian 32-bit words in 512-bit blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_padder
  import shapad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_msg_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_padded_word,
  output logic        out_block_end,
  output logic        out_run_last
);

  cmd_t    cmd;
  status_t st;

  // Sequencer for intake and padding.
  shapad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_has_byte(in_has_byte),
    .in_msg_end (in_msg_end),
    .st         (st),
    .cmd        (cmd)
  );

  // Block state and output register.
  shapad_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_padded_word(out_padded_word),
    .out_block_end  (out_block_end),
    .out_run_last   (out_run_last)
  );

endmodule

/* src/shapad_dp.sv */
// ----------------------------------------------------------------------------
// SHA-256 padder datapath
// Holds the block position, partial word and bit count, and the output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha256_message_padder_assert.svh"

module shapad_dp
  import shapad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  output status_t     st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_padded_word,
  output logic        out_block_end,
  output logic        out_run_last
);

  logic [5:0]  pos_r, pos_nxt;
  logic [23:0] part_r, part_nxt;
  logic [63:0] total_r, total_nxt;
  logic        ovld_r, ovld_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic        oend_r, oend_nxt;
  logic        olast_r, olast_nxt;
  logic        slot_free;
  logic [3:0]  widx_inc;
  logic [31:0] first_word;

  // The output register can take a word when empty or draining this cycle.
  assign slot_free = !ovld_r || out_ready;
  assign widx_inc  = pos_r[5:2] + 4'd1;

  assign st.slot_free = slot_free;
  assign st.at55      = (pos_r == POS_BEFORE_LEN);
  assign st.word_idx  = pos_r[5:2];

  // First padding word: gathered bytes, then the pad byte, then zeros.
  always_comb begin
    case (pos_r[1:0])
      2'd0:    first_word = {PAD_BYTE, 24'h0};
      2'd1:    first_word = {part_r[7:0], PAD_BYTE, 16'h0};
      2'd2:    first_word = {part_r[15:0], PAD_BYTE, 8'h0};
      default: first_word = {part_r[23:0], PAD_BYTE};
    endcase
  end

  // Next-state logic for the block state and the output beat.
  always_comb begin
    pos_nxt   = pos_r;
    part_nxt  = part_r;
    total_nxt = total_r;
    ovld_nxt  = ovld_r && !out_ready;
    oword_nxt = oword_r;
    oend_nxt  = oend_r;
    olast_nxt = olast_r;
    case (cmd.op)
      OP_BYTE: begin
        if (in_has_byte) begin
          pos_nxt   = pos_r + 6'd1;
          total_nxt = total_r + BYTE_BITS;
          if (pos_r[1:0] == 2'd3) begin
            part_nxt  = '0;
            ovld_nxt  = 1'b1;
            oword_nxt = {part_r, in_data_byte};
            oend_nxt  = (pos_r[5:2] == 4'd15);
            olast_nxt = cmd.last;
          end else begin
            part_nxt = {part_r[15:0], in_data_byte};
          end
        end
      end
      OP_PAD_FIRST: begin
        pos_nxt   = {widx_inc, 2'b00};
        part_nxt  = '0;
        ovld_nxt  = 1'b1;
        oword_nxt = first_word;
        oend_nxt  = (pos_r[5:2] == 4'd15);
        olast_nxt = 1'b0;
      end
      OP_PAD_ZERO: begin
        pos_nxt   = {widx_inc, 2'b00};
        ovld_nxt  = 1'b1;
        oword_nxt = '0;
        oend_nxt  = (pos_r[5:2] == 4'd15);
        olast_nxt = 1'b0;
      end
      OP_LEN_HI: begin
        pos_nxt   = {widx_inc, 2'b00};
        ovld_nxt  = 1'b1;
        oword_nxt = total_r[63:32];
        oend_nxt  = 1'b0;
        olast_nxt = 1'b0;
      end
      OP_LEN_LO: begin
        pos_nxt   = '0;
        part_nxt  = '0;
        total_nxt = '0;
        ovld_nxt  = 1'b1;
        oword_nxt = total_r[31:0];
        oend_nxt  = 1'b1;
        olast_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Block state and output valid reset; the output payload needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      part_r  <= '0;
      total_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      part_r  <= part_nxt;
      total_r <= total_nxt;
      ovld_r  <= ovld_nxt;
    end
    oword_r <= oword_nxt;
    oend_r  <= oend_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_padded_word = oword_r;
  assign out_block_end   = oend_r;
  assign out_run_last    = olast_r;

  // The controller only issues work when the output register has room.
  `SHAPAD_ASSERT_IMP(a_op_needs_slot, clk, rst_n, cmd.op != OP_NONE, slot_free)
  // The high length word always lands at byte 56 of a block.
  `SHAPAD_ASSERT_IMP(a_len_at_56, clk, rst_n, cmd.op == OP_LEN_HI, pos_r == 6'd56)
  // Finishing the length leaves the block state cleared.
  `SHAPAD_ASSERT_NXT(a_len_clears, clk, rst_n, cmd.op == OP_LEN_LO,
                     pos_r == 6'd0 && total_r == 64'd0 && part_r == 24'd0)

endmodule

/* src/shapad_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-256 padder controller
// Sequences byte intake and the padding burst, one word per cycle while the output has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shapad_ctrl
  import shapad_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_has_byte,
  input  logic    in_msg_end,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEND,
    S_PAD_FIRST,
    S_PAD_ZERO,
    S_LEN_HI,
    S_LEN_LO
  } state_t;

  state_t     state_r, state_nxt;
  logic       accept;
  logic       defer;
  logic [3:0] widx_inc;

  // Input is taken only when no padding is under way and the output has room.
  assign in_ready = ((state_r == S_IDLE) || (state_r == S_PEND)) && st.slot_free;
  assign accept   = in_valid && in_ready;
  // A final byte that fills the block to 56 bytes pushes padding to the next beat.
  assign defer    = in_has_byte && st.at55;
  assign widx_inc = st.word_idx + 4'd1;

  // Command decode and next state.
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.last  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op   = OP_BYTE;
          cmd.last = !in_msg_end || defer;
          if (in_msg_end) begin
            state_nxt = defer ? S_PEND : S_PAD_FIRST;
          end
        end
      end
      S_PEND: begin
        // The beat taken here is ignored; it only releases the padding.
        if (accept) begin
          state_nxt = S_PAD_FIRST;
        end
      end
      S_PAD_FIRST: begin
        if (st.slot_free) begin
          cmd.op    = OP_PAD_FIRST;
          state_nxt = (widx_inc == LEN_WORD_IDX) ? S_LEN_HI : S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        if (st.slot_free) begin
          cmd.op    = OP_PAD_ZERO;
          state_nxt = (widx_inc == LEN_WORD_IDX) ? S_LEN_HI : S_PAD_ZERO;
        end
      end
      S_LEN_HI: begin
        if (st.slot_free) begin
          cmd.op    = OP_LEN_HI;
          state_nxt = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (st.slot_free) begin
          cmd.op    = OP_LEN_LO;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
